FILE: rtl/core/ptsd_pkg.sv
// ============================================================================
// ptsd_pkg - shared types and constants for the pitch scale-degree snap
// Field widths, register indexes, scale modes, the degree-to-semitone table
// and the width helpers that every stage derives its datapath from.
// ============================================================================
package ptsd_pkg;

   localparam int PITCH_W       = 15;
   localparam int ROOT_W        = 7;
   localparam int MODE_W        = 3;
   localparam int DEGREE_W      = 9;
   localparam int SEMI_OUT_W    = 10;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 7;
   localparam int SCALE_SLOTS   = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_NOTE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_MODE = 1'b1;

   localparam logic [ROOT_W-1:0] ROOT_RESET = 7'd60;

   typedef enum logic [MODE_W-1:0] {
      MODE_MAJOR      = 3'd0,
      MODE_MINOR      = 3'd1,
      MODE_MELODIC    = 3'd2,
      MODE_HARMONIC   = 3'd3,
      MODE_PHRYGIAN   = 3'd4,
      MODE_PENTATONIC = 3'd5,
      MODE_CHROMATIC  = 3'd6,
      MODE_OCTAVE     = 3'd7
   } mode_type;

   // semitone of each slot above the octave base, unused slots zero
   localparam logic [3:0] SCALE_TAB [8][SCALE_SLOTS] = '{
      '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9,  4'd11, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8,  4'd10, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9,  4'd11, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8,  4'd11, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8,  4'd10, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd12, 4'd15, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,  4'd6,  4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0,  4'd0}
   };

   function automatic logic [3:0] degrees_per_oct(mode_type m);
      logic [3:0] n;
      unique case (m)
         MODE_CHROMATIC: n = 4'd12;
         MODE_OCTAVE:    n = 4'd1;
         default:        n = 4'd7;
      endcase
      return n;
   endfunction

   // bits of |pitch - root|
   function automatic int mag_width(int frac);
      return (PITCH_W > ROOT_W + frac) ? PITCH_W : ROOT_W + frac;
   endfunction

   function automatic int rel_width(int frac);
      return mag_width(frac) + 1;
   endfunction

   // bits of the rounded guess magnitude
   function automatic int quot_width(int frac);
      return mag_width(frac) + 3 - frac;
   endfunction

   function automatic int deg_width(int frac);
      return quot_width(frac) + 2;
   endfunction

   function automatic int semi_width(int frac);
      return deg_width(frac) + 5;
   endfunction

endpackage

FILE: rtl/core/ptsd_csr_if.sv
// ============================================================================
// ptsd_csr_if - register write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
interface ptsd_csr_if;
   import ptsd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);

endinterface

FILE: rtl/core/ptsd_req_if.sv
// ============================================================================
// ptsd_req_if - pitch request channel
// Valid/ready channel carrying one fixed-point pitch per request.
// ============================================================================
interface ptsd_req_if;
   import ptsd_pkg::*;

   logic               valid;
   logic               ready;
   logic [PITCH_W-1:0] pitch;

   modport source (output valid, pitch, input ready);
   modport sink   (input valid, pitch, output ready);

endinterface

FILE: rtl/core/ptsd_rsp_if.sv
// ============================================================================
// ptsd_rsp_if - snapped degree response channel
// Valid/ready channel carrying the chosen degree and its semitone offset.
// ============================================================================
interface ptsd_rsp_if;
   import ptsd_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DEGREE_W-1:0]   degree;
   logic signed [SEMI_OUT_W-1:0] semitone_offset;

   modport source (output valid, degree, semitone_offset, input ready);
   modport sink   (input valid, degree, semitone_offset, output ready);

endinterface

FILE: rtl/core/pitch_to_scale_degree_snap.sv
// ============================================================================
// pitch_to_scale_degree_snap - snap a fixed-point pitch to a scale degree
// Finds the degree of the configured scale nearest to the pitch, counted
// from the configured root, and returns it with its semitone offset.
// ============================================================================
//
//   channel  dir   handshake      payload
//   -------  ----  -------------  ------------------------------------------
//   csr_ch   in    valid / ready  index (0 root_note, 1 scale_mode), data
//   req_ch   in    valid / ready  pitch, unsigned, PITCH_FRACTION_BITS frac
//   rsp_ch   out   valid / ready  degree, semitone_offset (two's complement)
//
// One request per clock while the response side is not stalled; a request
// passes through one register stage each for the root offset, the
// scaling, the reciprocal divide, the octave split, the candidate lookup,
// the distances and the final pick (the output register).
// Reset clears every stage's valid bit and loads root 60, major mode.
// Each stage takes new data whenever it is empty or its successor moves,
// so a stalled response holds in place while bubbles behind it still fill.
// Register writes are always taken; write them only while the pipe is empty.
// ============================================================================
module pitch_to_scale_degree_snap #(
   parameter int PITCH_FRACTION_BITS = 8
) (
   input logic         clock,
   input logic         reset,
   ptsd_csr_if.sink    csr_ch,
   ptsd_req_if.sink    req_ch,
   ptsd_rsp_if.source  rsp_ch
);
   import ptsd_pkg::*;

   localparam int QW = quot_width(PITCH_FRACTION_BITS);
   localparam int RW = rel_width(PITCH_FRACTION_BITS);
   localparam int OW = deg_width(PITCH_FRACTION_BITS);
   localparam int SW = semi_width(PITCH_FRACTION_BITS);

   // configuration registers
   logic [ROOT_W-1:0] root_ff;
   mode_type          mode_ff;

   // guess -> split
   logic                 g_valid, g_ready, g_neg;
   logic [QW-1:0]        g_quot;
   logic signed [RW-1:0] g_rel;
   mode_type             g_mode;

   // split -> pick
   logic                 c_valid, c_ready;
   logic signed [OW-1:0] c_deg [3];
   logic signed [SW-1:0] c_semi [3];
   logic signed [RW-1:0] c_rel;

   // always take a register write; unknown indexes drop
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= ROOT_RESET;
         mode_ff <= MODE_MAJOR;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ROOT_NOTE:  root_ff <= csr_ch.data[ROOT_W-1:0];
            CSR_SCALE_MODE: mode_ff <= mode_type'(csr_ch.data[MODE_W-1:0]);
            default:        ;
         endcase
      end
   end

   // offset from root, rounded guess of the degree magnitude
   ptsd_guess #(
      .FRAC_BITS (PITCH_FRACTION_BITS)
   ) u_guess (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_pitch   (req_ch.pitch),
      .root_note  (root_ff),
      .scale_mode (mode_ff),
      .out_valid  (g_valid),
      .out_ready  (g_ready),
      .out_quot   (g_quot),
      .out_neg    (g_neg),
      .out_rel    (g_rel),
      .out_mode   (g_mode)
   );

   // guess-1, guess, guess+1 with their semitones
   ptsd_split #(
      .FRAC_BITS (PITCH_FRACTION_BITS)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_ready  (g_ready),
      .in_quot   (g_quot),
      .in_neg    (g_neg),
      .in_rel    (g_rel),
      .in_mode   (g_mode),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .out_deg   (c_deg),
      .out_semi  (c_semi),
      .out_rel   (c_rel)
   );

   // nearest candidate, held in the output register
   ptsd_pick #(
      .FRAC_BITS (PITCH_FRACTION_BITS)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid),
      .in_ready   (c_ready),
      .in_deg     (c_deg),
      .in_semi    (c_semi),
      .in_rel     (c_rel),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_degree (rsp_ch.degree),
      .out_semi   (rsp_ch.semitone_offset)
   );

endmodule

FILE: rtl/core/ptsd_guess.sv
// ============================================================================
// ptsd_guess - relative pitch and rounded degree guess
// Three stages: offset from root, scale by degrees per octave with rounding
// bias, divide by three through a reciprocal multiply.
// ============================================================================
module ptsd_guess #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_ready,
   input  logic [ptsd_pkg::PITCH_W-1:0]                 in_pitch,
   input  logic [ptsd_pkg::ROOT_W-1:0]                  root_note,
   input  ptsd_pkg::mode_type                           scale_mode,
   output logic                                         out_valid,
   input  logic                                         out_ready,
   output logic [ptsd_pkg::quot_width(FRAC_BITS)-1:0]   out_quot,
   output logic                                         out_neg,
   output logic signed [ptsd_pkg::rel_width(FRAC_BITS)-1:0] out_rel,
   output ptsd_pkg::mode_type                           out_mode
);
   import ptsd_pkg::*;

   localparam int MW  = mag_width(FRAC_BITS);
   localparam int RW  = rel_width(FRAC_BITS);
   localparam int UW  = quot_width(FRAC_BITS);
   localparam int NW  = MW + 4;
   localparam int AW  = MW + 5;
   localparam int K   = UW + 2;
   localparam logic [K-1:0] RECIP3 = K'(((64'd1 << K) + 64'd2) / 64'd3);

   logic rdy1, rdy2, rdy3;

   // stage 1: pitch relative to root
   logic                 s1_v_ff;
   logic signed [RW-1:0] s1_rel_in, s1_rel_ff;
   logic [MW-1:0]        s1_mag_in, s1_mag_ff;
   mode_type             s1_mode_ff;

   // stage 2: scaled, biased, shifted down
   logic                 s2_v_ff;
   logic [NW-1:0]        s2_num;
   logic [AW-1:0]        s2_sum;
   logic [UW-1:0]        s2_u_in, s2_u_ff;
   logic signed [RW-1:0] s2_rel_ff;
   mode_type             s2_mode_ff;

   // stage 3: divide by three
   logic                 s3_v_ff;
   logic [UW+K-1:0]      s3_prod;
   logic [UW-1:0]        s3_q_in, s3_q_ff;
   logic signed [RW-1:0] s3_rel_ff;
   mode_type             s3_mode_ff;

   assign rdy3     = !s3_v_ff || out_ready;
   assign rdy2     = !s2_v_ff || rdy3;
   assign rdy1     = !s1_v_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      s1_rel_in = RW'(in_pitch) - (RW'(root_note) << FRAC_BITS);
      s1_mag_in = s1_rel_in[RW-1] ? MW'(-s1_rel_in) : MW'(s1_rel_in);
   end

   always_comb begin
      unique case (s1_mode_ff)
         MODE_CHROMATIC: s2_num = (NW'(s1_mag_ff) << 3) + (NW'(s1_mag_ff) << 2);
         MODE_OCTAVE:    s2_num = NW'(s1_mag_ff);
         default:        s2_num = (NW'(s1_mag_ff) << 3) - NW'(s1_mag_ff);
      endcase
      // half of twelve steps as rounding bias, then drop fraction and /4
      s2_sum  = AW'(s2_num) + (AW'(6) << FRAC_BITS);
      s2_u_in = UW'(s2_sum >> (FRAC_BITS + 2));
   end

   always_comb begin
      s3_prod = (UW+K)'(s2_u_ff) * (UW+K)'(RECIP3);
      s3_q_in = UW'(s3_prod >> K);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (rdy1) s1_v_ff <= in_valid;
         if (rdy2) s2_v_ff <= s1_v_ff;
         if (rdy3) s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_rel_ff  <= s1_rel_in;
         s1_mag_ff  <= s1_mag_in;
         s1_mode_ff <= scale_mode;
      end
      if (rdy2 && s1_v_ff) begin
         s2_u_ff    <= s2_u_in;
         s2_rel_ff  <= s1_rel_ff;
         s2_mode_ff <= s1_mode_ff;
      end
      if (rdy3 && s2_v_ff) begin
         s3_q_ff    <= s3_q_in;
         s3_rel_ff  <= s2_rel_ff;
         s3_mode_ff <= s2_mode_ff;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_quot  = s3_q_ff;
   assign out_neg   = s3_rel_ff[RW-1];
   assign out_rel   = s3_rel_ff;
   assign out_mode  = s3_mode_ff;

endmodule

FILE: rtl/core/ptsd_split.sv
// ============================================================================
// ptsd_split - octave and slot of the guess and its two neighbours
// Two stages: floor division by degrees per octave, then slot wrap and
// table lookup for guess-1, guess and guess+1.
// ============================================================================
module ptsd_split #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [ptsd_pkg::quot_width(FRAC_BITS)-1:0]        in_quot,
   input  logic                                              in_neg,
   input  logic signed [ptsd_pkg::rel_width(FRAC_BITS)-1:0]  in_rel,
   input  ptsd_pkg::mode_type                                in_mode,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic signed [ptsd_pkg::deg_width(FRAC_BITS)-1:0]  out_deg [3],
   output logic signed [ptsd_pkg::semi_width(FRAC_BITS)-1:0] out_semi [3],
   output logic signed [ptsd_pkg::rel_width(FRAC_BITS)-1:0]  out_rel
);
   import ptsd_pkg::*;

   localparam int QW = quot_width(FRAC_BITS);
   localparam int RW = rel_width(FRAC_BITS);
   localparam int OW = deg_width(FRAC_BITS);
   localparam int SW = semi_width(FRAC_BITS);
   localparam int K7 = QW + 3;
   localparam int K3 = QW;
   localparam logic [K7-1:0] RECIP7 = K7'(((64'd1 << K7) + 64'd6) / 64'd7);
   localparam logic [K3-1:0] RECIP3 = K3'(((64'd1 << K3) + 64'd2) / 64'd3);

   function automatic logic signed [SW-1:0] semi_of(logic signed [OW-1:0] oct,
                                                    logic [3:0] idx, mode_type m);
      logic signed [SW-1:0] o;
      o = SW'(oct);
      return (o <<< 3) + (o <<< 2) + SW'(SCALE_TAB[m][idx]);
   endfunction

   logic rdy4, rdy5;

   // stage 4: octave count of the guess magnitude
   logic                 s4_v_ff;
   logic [QW+K7-1:0]     s4_p7;
   logic [QW+K3-1:0]     s4_p3;
   logic [QW-1:0]        s4_qd_in, s4_qd_ff, s4_q_ff;
   logic                 s4_neg_ff;
   logic signed [RW-1:0] s4_rel_ff;
   mode_type             s4_mode_ff;

   // stage 5: candidates
   logic                 s5_v_ff;
   logic [3:0]           s5_n, s5_nq, s5_rem, s5_idx, s5_idx_lo, s5_idx_hi;
   logic signed [OW-1:0] s5_qd_s, s5_q_s, s5_gdeg, s5_oct, s5_oct_lo, s5_oct_hi;
   logic signed [OW-1:0] s5_deg_in [3];
   logic signed [SW-1:0] s5_semi_in [3];
   logic signed [OW-1:0] s5_deg_ff [3];
   logic signed [SW-1:0] s5_semi_ff [3];
   logic signed [RW-1:0] s5_rel_ff;

   assign rdy5     = !s5_v_ff || out_ready;
   assign rdy4     = !s4_v_ff || rdy5;
   assign in_ready = rdy4;

   always_comb begin
      s4_p7 = (QW+K7)'(in_quot) * (QW+K7)'(RECIP7);
      s4_p3 = (QW+K3)'(in_quot >> 2) * (QW+K3)'(RECIP3);
      unique case (in_mode)
         MODE_CHROMATIC: s4_qd_in = QW'(s4_p3 >> K3);
         MODE_OCTAVE:    s4_qd_in = in_quot;
         default:        s4_qd_in = QW'(s4_p7 >> K7);
      endcase
   end

   always_comb begin
      s5_n = degrees_per_oct(s4_mode_ff);
      // remainder only needs the low bits of q - qd*n
      unique case (s4_mode_ff)
         MODE_CHROMATIC: s5_nq = (s4_qd_ff[3:0] << 3) + (s4_qd_ff[3:0] << 2);
         MODE_OCTAVE:    s5_nq = s4_qd_ff[3:0];
         default:        s5_nq = (s4_qd_ff[3:0] << 3) - s4_qd_ff[3:0];
      endcase
      s5_rem  = s4_q_ff[3:0] - s5_nq;
      s5_qd_s = $signed(OW'(s4_qd_ff));
      s5_q_s  = $signed(OW'(s4_q_ff));
      s5_gdeg = s4_neg_ff ? -s5_q_s : s5_q_s;

      // floor division with a non-negative slot
      if (s4_neg_ff && s5_rem != 4'd0) begin
         s5_oct = ~s5_qd_s;
         s5_idx = s5_n - s5_rem;
      end else begin
         s5_oct = s4_neg_ff ? -s5_qd_s : s5_qd_s;
         s5_idx = s5_rem;
      end

      if (s5_idx == 4'd0) begin
         s5_idx_lo = s5_n - 4'd1;
         s5_oct_lo = s5_oct - OW'(1);
      end else begin
         s5_idx_lo = s5_idx - 4'd1;
         s5_oct_lo = s5_oct;
      end

      if (s5_idx == s5_n - 4'd1) begin
         s5_idx_hi = 4'd0;
         s5_oct_hi = s5_oct + OW'(1);
      end else begin
         s5_idx_hi = s5_idx + 4'd1;
         s5_oct_hi = s5_oct;
      end

      s5_deg_in[0]  = s5_gdeg - OW'(1);
      s5_deg_in[1]  = s5_gdeg;
      s5_deg_in[2]  = s5_gdeg + OW'(1);
      s5_semi_in[0] = semi_of(s5_oct_lo, s5_idx_lo, s4_mode_ff);
      s5_semi_in[1] = semi_of(s5_oct, s5_idx, s4_mode_ff);
      s5_semi_in[2] = semi_of(s5_oct_hi, s5_idx_hi, s4_mode_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (rdy4) s4_v_ff <= in_valid;
         if (rdy5) s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && in_valid) begin
         s4_qd_ff   <= s4_qd_in;
         s4_q_ff    <= in_quot;
         s4_neg_ff  <= in_neg;
         s4_rel_ff  <= in_rel;
         s4_mode_ff <= in_mode;
      end
      if (rdy5 && s4_v_ff) begin
         s5_deg_ff  <= s5_deg_in;
         s5_semi_ff <= s5_semi_in;
         s5_rel_ff  <= s4_rel_ff;
      end
   end

   assign out_valid = s5_v_ff;
   assign out_deg   = s5_deg_ff;
   assign out_semi  = s5_semi_ff;
   assign out_rel   = s5_rel_ff;

endmodule

FILE: rtl/core/ptsd_pick.sv
// ============================================================================
// ptsd_pick - distance compare and output register
// Two stages: absolute distance of each candidate to the pitch, then pick
// the nearest, lower degree first on a tie.
// ============================================================================
module ptsd_pick #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic signed [ptsd_pkg::deg_width(FRAC_BITS)-1:0]  in_deg [3],
   input  logic signed [ptsd_pkg::semi_width(FRAC_BITS)-1:0] in_semi [3],
   input  logic signed [ptsd_pkg::rel_width(FRAC_BITS)-1:0]  in_rel,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic signed [ptsd_pkg::DEGREE_W-1:0]              out_degree,
   output logic signed [ptsd_pkg::SEMI_OUT_W-1:0]            out_semi
);
   import ptsd_pkg::*;

   localparam int RW = rel_width(FRAC_BITS);
   localparam int OW = deg_width(FRAC_BITS);
   localparam int SW = semi_width(FRAC_BITS);
   localparam int XW = ((SW + FRAC_BITS > RW) ? SW + FRAC_BITS : RW) + 1;

   logic rdy6, rdy7;

   // stage 6: distances
   logic                 s6_v_ff;
   logic signed [XW-1:0] s6_diff [3];
   logic [XW-1:0]        s6_dist_in [3];
   logic [XW-1:0]        s6_dist_ff [3];
   logic signed [OW-1:0] s6_deg_ff [3];
   logic signed [SW-1:0] s6_semi_ff [3];

   // stage 7: selection, output register
   logic                          s7_v_ff;
   logic [1:0]                    s7_sel;
   logic [XW-1:0]                 s7_best_dist;
   logic signed [DEGREE_W-1:0]    s7_deg_in, s7_deg_ff;
   logic signed [SEMI_OUT_W-1:0]  s7_semi_in, s7_semi_ff;

   assign rdy7     = !s7_v_ff || out_ready;
   assign rdy6     = !s6_v_ff || rdy7;
   assign in_ready = rdy6;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_diff[i]    = (XW'(in_semi[i]) <<< FRAC_BITS) - XW'(in_rel);
         s6_dist_in[i] = s6_diff[i][XW-1] ? XW'(-s6_diff[i]) : XW'(s6_diff[i]);
      end
   end

   always_comb begin
      // strict compares keep the lower degree on a tie
      if (s6_dist_ff[1] < s6_dist_ff[0]) begin
         s7_sel       = 2'd1;
         s7_best_dist = s6_dist_ff[1];
      end else begin
         s7_sel       = 2'd0;
         s7_best_dist = s6_dist_ff[0];
      end
      if (s6_dist_ff[2] < s7_best_dist) begin
         s7_sel = 2'd2;
      end
      s7_deg_in  = s6_deg_ff[s7_sel][DEGREE_W-1:0];
      s7_semi_in = s6_semi_ff[s7_sel][SEMI_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else begin
         if (rdy6) s6_v_ff <= in_valid;
         if (rdy7) s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6 && in_valid) begin
         s6_dist_ff <= s6_dist_in;
         s6_deg_ff  <= in_deg;
         s6_semi_ff <= in_semi;
      end
      if (rdy7 && s6_v_ff) begin
         s7_deg_ff  <= s7_deg_in;
         s7_semi_ff <= s7_semi_in;
      end
   end

   assign out_valid  = s7_v_ff;
   assign out_degree = s7_deg_ff;
   assign out_semi   = s7_semi_ff;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the pitch scale-degree snap
// Streams fixed-point pitches through the block under several root and mode
// settings and idling patterns. A local predictor works out each snapped
// degree and semitone offset when the request is taken, and every response
// is checked in order against it.
// ============================================================================
module tb;
   import ptsd_pkg::*;

   localparam int FRAC_BITS   = 8;
   localparam int LATENCY     = 7;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 16;
   localparam int PHASE_ITEMS = 47;

   typedef struct {
      logic [PITCH_W-1:0]           pitch;
      logic signed [DEGREE_W-1:0]   degree;
      logic signed [SEMI_OUT_W-1:0] semitone_offset;
   } snap_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptsd_csr_if csr_ch ();
   ptsd_req_if req_ch ();
   ptsd_rsp_if rsp_ch ();

   pitch_to_scale_degree_snap #(
      .PITCH_FRACTION_BITS (FRAC_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // pitches waiting to be offered, and predictions waiting for their response
   logic [PITCH_W-1:0] pitch_queue [$];
   snap_type           snap_queue [$];

   // shadow of the block's registers, updated on each accepted write
   logic [ROOT_W-1:0] root_shadow = ROOT_RESET;
   mode_type          mode_shadow = MODE_MAJOR;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int pitches_queued = 0;
   int pitches_taken = 0;
   int snaps_seen = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("%0t ERROR %s", $time, msg);
      fail_count++;
   endtask

   // Nearest degree of the scale to the pitch. The first guess is the scaled
   // relative pitch rounded half away from zero; its two neighbours are tried
   // as well and on equal distance the lower degree is kept.
   function automatic snap_type snap_pitch(logic [PITCH_W-1:0] pitch,
                                           logic [ROOT_W-1:0] root, mode_type mode);
      snap_type    res;
      longint      unit, steps, rel, num, den, mag, q, guess, d, oct, slot;
      longint      semi, gap, best_deg, best_semi, best_gap;
      logic [47:0] row;
      unit = longint'(1) << FRAC_BITS;
      // slot k of the octave sits in nibble k
      case (mode)
         MODE_MAJOR:      row = 48'h0000_0B97_5420;
         MODE_MINOR:      row = 48'h0000_0A87_5320;
         MODE_MELODIC:    row = 48'h0000_0B97_5320;
         MODE_HARMONIC:   row = 48'h0000_0B87_5320;
         MODE_PHRYGIAN:   row = 48'h0000_0A87_5310;
         MODE_PENTATONIC: row = 48'h0000_0FCA_7530;
         MODE_CHROMATIC:  row = 48'hBA98_7654_3210;
         default:         row = 48'h0;
      endcase
      case (mode)
         MODE_CHROMATIC: steps = 12;
         MODE_OCTAVE:    steps = 1;
         default:        steps = 7;
      endcase
      rel   = longint'(pitch) - longint'(root) * unit;
      num   = rel * steps;
      den   = 12 * unit;
      mag   = (num < 0) ? -num : num;
      q     = (2 * mag + den) / (2 * den);
      guess = (num < 0) ? -q : q;
      best_deg  = guess;
      best_semi = 0;
      best_gap  = -1;
      for (d = guess - 1; d <= guess + 1; d++) begin
         // floor division, so negative degrees land in the octave below
         oct = d / steps;
         if ((d % steps) != 0 && d < 0) oct--;
         slot = d - oct * steps;
         semi = oct * 12 + longint'(row[slot*4 +: 4]);
         gap  = semi * unit - rel;
         if (gap < 0) gap = -gap;
         if (best_gap < 0 || gap < best_gap) begin
            best_gap  = gap;
            best_deg  = d;
            best_semi = semi;
         end
      end
      res.pitch           = pitch;
      res.degree          = DEGREE_W'(best_deg);
      res.semitone_offset = SEMI_OUT_W'(best_semi);
      return res;
   endfunction

   // Request driver: offer the next queued pitch unless told to idle, hold it
   // until taken, and put noise on the pitch while nothing is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pitch_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.pitch <= pitch_queue.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
            req_ch.pitch <= PITCH_W'($urandom);
         end
      end
   end

   // Monitor: track register writes, predict each accepted request, check
   // each accepted response against the oldest prediction, and drive the
   // response-side stalls.
   always @(posedge clock) begin
      snap_type exp_snap;
      if (reset) begin
         quiet_cycles <= 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_ROOT_NOTE) root_shadow = csr_ch.data[ROOT_W-1:0];
            else                               mode_shadow = mode_type'(csr_ch.data[MODE_W-1:0]);
         end
         if (req_ch.valid && req_ch.ready) begin
            snap_queue.push_back(snap_pitch(req_ch.pitch, root_shadow, mode_shadow));
            pitches_taken <= pitches_taken + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            snaps_seen <= snaps_seen + 1;
            if (snap_queue.size() == 0) begin
               report_mismatch($sformatf("response with nothing pending: degree %0d semis %0d",
                                         rsp_ch.degree, rsp_ch.semitone_offset));
            end else begin
               exp_snap = snap_queue.pop_front();
               if (rsp_ch.degree !== exp_snap.degree)
                  report_mismatch($sformatf("pitch %h: degree %0d, predicted %0d",
                                            exp_snap.pitch, rsp_ch.degree, exp_snap.degree));
               if (rsp_ch.semitone_offset !== exp_snap.semitone_offset)
                  report_mismatch($sformatf("pitch %h: semitone_offset %0d, predicted %0d",
                                            exp_snap.pitch, rsp_ch.semitone_offset,
                                            exp_snap.semitone_offset));
            end
         end
         if ((csr_ch.valid && csr_ch.ready) || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Give up when nothing has moved on any channel for too long.
   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic queue_pitch(logic [PITCH_W-1:0] pitch);
      pitch_queue.push_back(pitch);
      pitches_queued++;
   endtask

   // Hold off until every queued request is taken and answered, then let the
   // pipe drain before anything else happens.
   task automatic settle();
      while (pitches_taken != pitches_queued || snaps_seen != pitches_taken)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_scale(logic [ROOT_W-1:0] root, mode_type mode);
      settle();
      write_reg(CSR_ROOT_NOTE, root);
      write_reg(CSR_SCALE_MODE, CSR_DATA_W'(mode));
   endtask

   initial begin : stimulus
      int                p, n;
      logic [ROOT_W-1:0] root;
      logic [7:0]        frac;
      // drive every input to a known level from time zero
      req_ch.valid = 1'b0;
      req_ch.pitch = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_ROOT_NOTE;
      csr_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings (root 60, major): both pitch extremes, the
      // root itself, a tie between two degrees, half a semitone above and just
      // below the root, a first guess that lands exactly on one half going up
      // and going down, and alternating bit patterns.
      queue_pitch(15'd0);
      queue_pitch(15'd32767);
      queue_pitch(15'(60 * 256));
      queue_pitch(15'(61 * 256));
      queue_pitch(15'(60 * 256 + 128));
      queue_pitch(15'(60 * 256 - 1));
      queue_pitch(15'((60 + 42) * 256));
      queue_pitch(15'((60 - 42) * 256));
      queue_pitch(15'h5555);
      queue_pitch(15'h2AAA);

      // chromatic from the bottom: half-semitone ties and the top pitch
      set_scale(7'd0, MODE_CHROMATIC);
      queue_pitch(15'd128);
      queue_pitch(15'd384);
      queue_pitch(15'd32767);
      queue_pitch(15'd0);

      // octaves only from the top root: tritone ties and far negative degrees
      set_scale(7'd127, MODE_OCTAVE);
      queue_pitch(15'd0);
      queue_pitch(15'd32767);
      queue_pitch(15'((127 - 6) * 256));
      queue_pitch(15'((127 - 18) * 256));

      // padded pentatonic slots near the top
      set_scale(7'd127, MODE_PENTATONIC);
      queue_pitch(15'd32767);
      queue_pitch(15'((127 - 4) * 256 + 128));
      queue_pitch(15'd0);

      // Random phases: every mode twice, roots at both ends and in between,
      // and each idling pattern in turn. Each phase boundary pauses the
      // sender until every response is in.
      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0:       root = 7'd0;
            1:       root = 7'd127;
            default: root = ROOT_W'($urandom_range(127));
         endcase
         set_scale(root, mode_type'(p % 8));
         case ((p / 2) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // weight towards whole and half semitones, where ties live
            if ($urandom_range(9) < 4) begin
               case ($urandom_range(5))
                  0: frac = 8'd0;
                  1: frac = 8'd1;
                  2: frac = 8'd127;
                  3: frac = 8'd128;
                  4: frac = 8'd129;
                  default: frac = 8'd255;
               endcase
               queue_pitch(PITCH_W'($urandom_range(127) * 256 + frac));
            end else begin
               queue_pitch(PITCH_W'($urandom_range(32767)));
            end
         end
      end

      // wait for the last responses, then a little longer for strays
      while (pitches_taken != pitches_queued || snaps_seen != pitches_taken)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (snap_queue.size() != 0)
         report_mismatch($sformatf("%0d predictions left unanswered", snap_queue.size()));
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/ptsd_pkg.sv
rtl/core/ptsd_csr_if.sv
rtl/core/ptsd_req_if.sv
rtl/core/ptsd_rsp_if.sv
rtl/core/ptsd_guess.sv
rtl/core/ptsd_split.sv
rtl/core/ptsd_pick.sv
rtl/core/pitch_to_scale_degree_snap.sv
tb/sv/tb.sv
